### hw/rtl/psr_pkg.sv
// ----------------------------------------------------------------------------
// psr_pkg
// shared types, codes and defaults of the psi section reassembler
// ----------------------------------------------------------------------------
package psr_pkg;

   localparam int CHANNELS_DEFAULT    = 16;
   localparam int MAX_SECTION_DEFAULT = 4096;

   // result kinds
   localparam logic [1:0] KIND_SECTION_BYTE = 2'd0;
   localparam logic [1:0] KIND_ABORTED      = 2'd1;
   localparam logic [1:0] KIND_BAD_LENGTH   = 2'd2;
   localparam logic [1:0] KIND_PTR_OVERRUN  = 2'd3;

   localparam logic [7:0]  STUFF_BYTE   = 8'hff;
   localparam logic [12:0] HEADER_BYTES = 13'd3;
   localparam logic [12:0] LEN_HI_BYTE  = 13'd2;

   typedef struct packed {
      logic [3:0] channel;
      logic       pusi;
      logic       payload_first;
      logic       payload_last;
      logic [7:0] data_byte;
   } req_word_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] out_channel;
      logic [7:0] out_byte;
      logic       section_start;
      logic       section_end;
   } rsp_word_type;

   // per-channel section state
   typedef struct packed {
      logic [12:0] sec_len;
      logic [12:0] byte_count;
      logic [3:0]  header_len_high;
   } chan_state_type;

   function automatic rsp_word_type make_result(logic [1:0] kind, logic [3:0] ch,
                                                logic [7:0] b, logic st, logic en);
      rsp_word_type r;
      r.kind          = kind;
      r.out_channel   = ch;
      r.out_byte      = b;
      r.section_start = st;
      r.section_end   = en;
      return r;
   endfunction

endpackage

### hw/rtl/psr_stream_if.sv
// ----------------------------------------------------------------------------
// psr_stream_if
// valid/ready word channel with a typed payload
// ----------------------------------------------------------------------------
interface psr_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/psi_section_reassembler.sv
// ----------------------------------------------------------------------------
// psi_section_reassembler
// streams psi sections out of transport-stream payload words per channel slot
// ----------------------------------------------------------------------------
// path: an accepted word is held in the input register, then the state update
//   and queue push follow once the output queue has room for two results
// throughput: one payload word per cycle while the output queue has room for two
//   results, set by the single read-modify-write of the channel state memory
// reset: after reset a clearing pass zeroes the channel state memory, one entry
//   per cycle, and no word is accepted meanwhile
// ----------------------------------------------------------------------------
module psi_section_reassembler import psr_pkg::*; #(
   parameter int CHANNELS    = CHANNELS_DEFAULT,
   parameter int MAX_SECTION = MAX_SECTION_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   psr_stream_if.sink   req,
   psr_stream_if.source rsp
);

   localparam int IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int FIFO_DEPTH = 4;
   localparam int FPTR_W     = $clog2(FIFO_DEPTH);
   localparam int FCNT_W     = FPTR_W + 1;

   typedef enum logic [1:0] {PH_IDLE, PH_POINTER, PH_SECTION} phase_type;

   typedef struct packed {
      chan_state_type st;
      rsp_word_type   res;
      logic           bad;
   } take_type;

   // adds one byte to the open section of a channel
   function automatic take_type take_byte(chan_state_type s, logic [7:0] b,
                                          logic [3:0] ch);
      take_type    t;
      logic [12:0] have;
      logic [12:0] total;
      logic        start;
      have  = s.byte_count + 13'd1;
      start = (s.byte_count == 13'd0);
      total = 13'({s.header_len_high, b}) + HEADER_BYTES;
      t.st  = s;
      t.bad = 1'b0;
      t.res = make_result(KIND_SECTION_BYTE, ch, b, start, 1'b0);
      if (s.sec_len == 13'd0) begin
         if (have == LEN_HI_BYTE) t.st.header_len_high = b[3:0];
         if (have == HEADER_BYTES) begin
            if (32'(total) > MAX_SECTION) begin
               t.bad = 1'b1;
            end else begin
               t.st.sec_len = total;
            end
         end
      end
      if (t.bad) begin
         t.st  = '0;
         t.res = make_result(KIND_BAD_LENGTH, ch, 8'd0, 1'b0, 1'b0);
      end else if (t.st.sec_len != 13'd0 && have >= t.st.sec_len) begin
         // last byte of the section
         t.st  = '0;
         t.res = make_result(KIND_SECTION_BYTE, ch, b, start, 1'b1);
      end else begin
         t.st.byte_count = have;
      end
      return t;
   endfunction

   // channel state memory and its clearing sweep
   chan_state_type chan_mem_ff [CHANNELS];
   chan_state_type chan_rd_ff;
   logic           clr_active_ff, clr_active_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;

   // input register
   logic         s1_valid_ff, s1_valid_in;
   req_word_type s1_word_ff;

   // last written channel state, covers the read that raced the write
   logic           last_valid_ff, last_valid_in;
   logic [3:0]     last_ch_ff;
   chan_state_type last_st_ff;

   phase_type  phase_ff, phase_in;
   logic [7:0] pointer_ff, pointer_in;

   // output queue
   rsp_word_type      fifo_ff [FIFO_DEPTH];
   logic [FPTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [FCNT_W-1:0] cnt_ff, cnt_in;

   logic req_take;
   logic rsp_take;
   logic s1_go;
   logic in_range;

   chan_state_type cur_st;
   chan_state_type st_v;
   take_type       t_v;
   phase_type      ph_v;
   logic [7:0]     pl_v;
   rsp_word_type   r0_v, r1_v;
   logic [1:0]     n_v;
   logic           skip_v;

   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   chan_state_type   mem_wd;

   // handshakes; the stage moves on only with room for two results
   assign s1_go     = s1_valid_ff && (cnt_ff <= FCNT_W'(FIFO_DEPTH - 2));
   assign req.ready = !clr_active_ff && (!s1_valid_ff || s1_go);
   assign req_take  = req.valid && req.ready;
   assign rsp.valid = (cnt_ff != '0);
   assign rsp.payload = fifo_ff[rp_ff];
   assign rsp_take  = rsp.valid && rsp.ready;

   assign in_range = (32'(s1_word_ff.channel) < CHANNELS);
   assign cur_st   = (last_valid_ff && last_ch_ff == s1_word_ff.channel) ?
                     last_st_ff : chan_rd_ff;

   // one payload word through the pointer and section logic
   always_comb begin
      st_v   = cur_st;
      ph_v   = phase_ff;
      pl_v   = pointer_ff;
      r0_v   = '0;
      r1_v   = '0;
      n_v    = 2'd0;
      skip_v = 1'b0;
      t_v    = take_byte(cur_st, s1_word_ff.data_byte, s1_word_ff.channel);
      if (!in_range) begin
         if (s1_word_ff.payload_first || s1_word_ff.payload_last) ph_v = PH_IDLE;
      end else if (s1_word_ff.payload_first && s1_word_ff.pusi) begin
         // pointer field
         pl_v = s1_word_ff.data_byte;
         if (s1_word_ff.data_byte == 8'd0) begin
            if (st_v.byte_count != 13'd0) begin
               st_v = '0;
               r0_v = make_result(KIND_ABORTED, s1_word_ff.channel, 8'd0, 1'b0, 1'b0);
               n_v  = 2'd1;
            end
            ph_v = PH_SECTION;
         end else if (s1_word_ff.payload_last) begin
            st_v = '0;
            pl_v = 8'd0;
            r0_v = make_result(KIND_PTR_OVERRUN, s1_word_ff.channel, 8'd0, 1'b0, 1'b0);
            n_v  = 2'd1;
         end else begin
            ph_v = PH_POINTER;
         end
         if (s1_word_ff.payload_last) ph_v = PH_IDLE;
      end else begin
         if (s1_word_ff.payload_first) begin
            // continuation packet without open section is dropped
            if (st_v.byte_count == 13'd0) begin
               ph_v   = PH_IDLE;
               skip_v = 1'b1;
            end else begin
               ph_v = PH_SECTION;
            end
         end
         if (!skip_v && ph_v == PH_POINTER) begin
            if (cur_st.byte_count != 13'd0) begin
               st_v = t_v.st;
               r0_v = t_v.res;
               n_v  = 2'd1;
            end
            if (pl_v != 8'd0) pl_v = pl_v - 8'd1;
            if (cur_st.byte_count != 13'd0 && t_v.bad) begin
               ph_v = PH_IDLE;
            end else if (pl_v == 8'd0) begin
               // pointer used up; a section that is still open is aborted
               if (st_v.byte_count != 13'd0) begin
                  st_v = '0;
                  if (n_v == 2'd0) begin
                     r0_v = make_result(KIND_ABORTED, s1_word_ff.channel, 8'd0,
                                        1'b0, 1'b0);
                  end else begin
                     r1_v = make_result(KIND_ABORTED, s1_word_ff.channel, 8'd0,
                                        1'b0, 1'b0);
                  end
                  n_v = n_v + 2'd1;
               end
               ph_v = PH_SECTION;
            end else if (s1_word_ff.payload_last) begin
               st_v = '0;
               pl_v = 8'd0;
               if (n_v == 2'd0) begin
                  r0_v = make_result(KIND_PTR_OVERRUN, s1_word_ff.channel, 8'd0,
                                     1'b0, 1'b0);
               end else begin
                  r1_v = make_result(KIND_PTR_OVERRUN, s1_word_ff.channel, 8'd0,
                                     1'b0, 1'b0);
               end
               n_v = n_v + 2'd1;
            end
         end else if (!skip_v && ph_v == PH_SECTION) begin
            if (cur_st.byte_count == 13'd0 && s1_word_ff.data_byte == STUFF_BYTE) begin
               ph_v = PH_IDLE;
            end else begin
               st_v = t_v.st;
               r0_v = t_v.res;
               n_v  = 2'd1;
               if (t_v.bad) ph_v = PH_IDLE;
            end
         end
         if (s1_word_ff.payload_last) ph_v = PH_IDLE;
      end
   end

   // memory write port: clearing sweep or state update
   always_comb begin
      mem_we = 1'b0;
      mem_wa = clr_idx_ff;
      mem_wd = '0;
      if (clr_active_ff) begin
         mem_we = 1'b1;
      end else if (s1_go && in_range) begin
         mem_we = 1'b1;
         mem_wa = IDX_W'(s1_word_ff.channel);
         mem_wd = st_v;
      end
   end

   // next values of the control registers
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_idx_in    = clr_idx_ff;
      if (clr_active_ff) begin
         if (clr_idx_ff == IDX_W'(CHANNELS - 1)) clr_active_in = 1'b0;
         else clr_idx_in = clr_idx_ff + IDX_W'(1);
      end
      s1_valid_in   = req_take || (s1_valid_ff && !s1_go);
      last_valid_in = last_valid_ff || (s1_go && in_range);
      phase_in      = s1_go ? ph_v : phase_ff;
      pointer_in    = s1_go ? pl_v : pointer_ff;
      wp_in         = s1_go ? wp_ff + FPTR_W'(n_v) : wp_ff;
      rp_in         = rsp_take ? rp_ff + FPTR_W'(1) : rp_ff;
      cnt_in        = cnt_ff + (s1_go ? FCNT_W'(n_v) : '0) - FCNT_W'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         last_valid_ff <= 1'b0;
         phase_ff      <= PH_IDLE;
         pointer_ff    <= 8'd0;
         wp_ff         <= '0;
         rp_ff         <= '0;
         cnt_ff        <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_idx_ff    <= clr_idx_in;
         s1_valid_ff   <= s1_valid_in;
         last_valid_ff <= last_valid_in;
         phase_ff      <= phase_in;
         pointer_ff    <= pointer_in;
         wp_ff         <= wp_in;
         rp_ff         <= rp_in;
         cnt_ff        <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) s1_word_ff <= req.payload;
      if (s1_go && in_range) begin
         last_ch_ff <= s1_word_ff.channel;
         last_st_ff <= st_v;
      end
      if (s1_go && n_v != 2'd0) fifo_ff[wp_ff] <= r0_v;
      if (s1_go && n_v == 2'd2) fifo_ff[wp_ff + FPTR_W'(1)] <= r1_v;
   end

   // channel state memory, registered read at accept
   always_ff @(posedge clock) begin
      if (mem_we) chan_mem_ff[mem_wa] <= mem_wd;
      if (req_take) chan_rd_ff <= chan_mem_ff[IDX_W'(req.payload.channel)];
   end

   // queue never overfills
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FCNT_W'(FIFO_DEPTH))
      else $error("output queue overflow");

   // the clearing sweep runs once after reset only
   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      !clr_active_ff |=> !clr_active_ff)
      else $error("clearing sweep restarted");

   // no word enters while the state memory is being cleared
   a_no_take_clear: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |=> !s1_valid_ff)
      else $error("word taken during clearing sweep");

   // status results carry no byte and no marks
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.payload.kind != KIND_SECTION_BYTE) |->
      (rsp.payload.out_byte == 8'd0 && !rsp.payload.section_start &&
       !rsp.payload.section_end))
      else $error("status result with byte data");

endmodule
